### rtl/core/wsfp_pkg.sv
package wsfp_pkg;

    // Width of the decoded length held inside the parser (16 to 64).
    localparam int LENGTH_BITS = 64;

    // Fixed field widths of the stream.
    localparam int BYTE_W        = 8;
    localparam int OPCODE_W      = 4;
    localparam int PAYLOAD_LEN_W = 64;
    localparam int HDR_CNT_W     = 4;

    // Header byte fields and length codes.
    localparam logic [BYTE_W-1:0] FLAG_BIT_MASK = 8'h80;
    localparam logic [BYTE_W-1:0] OPCODE_MASK   = 8'h0F;
    localparam logic [BYTE_W-1:0] LEN_CODE_MASK = 8'h7F;
    localparam logic [6:0]        LEN_CODE_16   = 7'd126;
    localparam logic [6:0]        LEN_CODE_64   = 7'd127;

    // Header byte counts that follow the second header byte.
    localparam logic [HDR_CNT_W-1:0] EXT_BYTES_16 = 4'd2;
    localparam logic [HDR_CNT_W-1:0] EXT_BYTES_64 = 4'd8;
    localparam logic [HDR_CNT_W-1:0] KEY_BYTES    = 4'd4;

    // Result kinds.
    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    // Width of the packed master-side tdata (rounded up to whole bytes).
    localparam int RES_DATA_BITS = 1 + OPCODE_W + 1 + PAYLOAD_LEN_W + BYTE_W;
    localparam int M_TDATA_W     = ((RES_DATA_BITS + 7) / 8) * 8;

    // One result item.
    typedef struct packed {
        logic                     kind;
        logic                     final_flag;
        logic [OPCODE_W-1:0]      frame_opcode;
        logic                     mask_flag;
        logic [PAYLOAD_LEN_W-1:0] payload_length;
        logic [BYTE_W-1:0]        payload_byte;
        logic                     last;
    } res_t;

endpackage

### rtl/core/wsfp_parse.sv
module wsfp_parse (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_fire,
    input  logic [wsfp_pkg::BYTE_W-1:0]  in_byte,
    output logic                         res_valid,
    output wsfp_pkg::res_t               res
);
    import wsfp_pkg::*;

    typedef enum logic [1:0] {
        PH_HDR0,
        PH_HDR1,
        PH_EXT,
        PH_DATA
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [HDR_CNT_W-1:0]   hdr_cnt_reg, hdr_cnt_next;
    logic                   final_reg, final_next;
    logic [OPCODE_W-1:0]    opcode_reg, opcode_next;
    logic                   masked_reg, masked_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [31:0]            key_reg, key_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [1:0]             kidx_reg, kidx_next;

    logic [HDR_CNT_W-1:0]   key_part;
    logic [HDR_CNT_W-1:0]   ext_cnt;
    logic [HDR_CNT_W-1:0]   hdr_cnt_dec;
    logic [6:0]             len_code;
    logic [BYTE_W-1:0]      key_byte;
    logic [LENGTH_BITS-1:0] left_dec;
    logic                   hdr_done;

    // Helper values for the header and payload steps.
    always_comb
    begin
        len_code    = 7'(in_byte & LEN_CODE_MASK);
        key_part    = masked_reg ? KEY_BYTES : '0;
        hdr_cnt_dec = hdr_cnt_reg - 1'b1;
        left_dec    = left_reg - 1'b1;
        // Key bytes are used from the most significant byte down.
        key_byte    = BYTE_W'(key_reg >> {~kidx_reg, 3'b000});
        if (len_code == LEN_CODE_16)
        begin
            ext_cnt = EXT_BYTES_16;
        end
        else if (len_code == LEN_CODE_64)
        begin
            ext_cnt = EXT_BYTES_64;
        end
        else
        begin
            ext_cnt = '0;
        end
    end

    // Next state and the result for the byte in hand.
    always_comb
    begin
        phase_next   = phase_reg;
        hdr_cnt_next = hdr_cnt_reg;
        final_next   = final_reg;
        opcode_next  = opcode_reg;
        masked_next  = masked_reg;
        len_next     = len_reg;
        key_next     = key_reg;
        left_next    = left_reg;
        kidx_next    = kidx_reg;
        hdr_done     = 1'b0;
        res_valid    = 1'b0;

        unique case (phase_reg)
            PH_HDR0:
            begin
                final_next  = |(in_byte & FLAG_BIT_MASK);
                opcode_next = OPCODE_W'(in_byte & OPCODE_MASK);
                phase_next  = PH_HDR1;
            end
            PH_HDR1:
            begin
                masked_next  = |(in_byte & FLAG_BIT_MASK);
                key_next     = '0;
                len_next     = (ext_cnt == '0) ? LENGTH_BITS'(len_code) : '0;
                hdr_cnt_next = ext_cnt + (masked_next ? KEY_BYTES : '0);
                if (hdr_cnt_next == '0)
                begin
                    hdr_done = 1'b1;
                end
                else
                begin
                    phase_next = PH_EXT;
                end
            end
            PH_EXT:
            begin
                // Length bytes come first, then the masking key.
                if (hdr_cnt_reg > key_part)
                begin
                    len_next = {len_reg[LENGTH_BITS-BYTE_W-1:0], in_byte};
                end
                else
                begin
                    key_next = {key_reg[31-BYTE_W:0], in_byte};
                end
                hdr_cnt_next = hdr_cnt_dec;
                hdr_done     = (hdr_cnt_dec == '0);
            end
            PH_DATA:
            begin
                left_next = left_dec;
                kidx_next = kidx_reg + 1'b1;
                res_valid = 1'b1;
                if (left_dec == '0)
                begin
                    phase_next = PH_HDR0;
                end
            end
            default:
            begin
                phase_next = PH_HDR0;
            end
        endcase

        // A complete header starts the payload or, for an empty frame, the next frame.
        if (hdr_done)
        begin
            res_valid = 1'b1;
            if (len_next == '0)
            begin
                phase_next = PH_HDR0;
            end
            else
            begin
                left_next  = len_next;
                kidx_next  = '0;
                phase_next = PH_DATA;
            end
        end

        res_valid &= in_fire;

        res.final_flag     = final_next;
        res.frame_opcode   = opcode_next;
        res.mask_flag      = masked_next;
        res.payload_length = PAYLOAD_LEN_W'(len_next);
        if (phase_reg == PH_DATA)
        begin
            res.kind         = KIND_PAYLOAD;
            res.payload_byte = in_byte ^ key_byte;
            res.last         = (left_dec == '0);
        end
        else
        begin
            res.kind         = KIND_HEADER;
            res.payload_byte = '0;
            res.last         = (len_next == '0);
        end
    end

    // Parser state, updated on every accepted byte.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_HDR0;
            hdr_cnt_reg <= '0;
            final_reg   <= 1'b0;
            opcode_reg  <= '0;
            masked_reg  <= 1'b0;
            len_reg     <= '0;
            key_reg     <= '0;
            left_reg    <= '0;
            kidx_reg    <= '0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            hdr_cnt_reg <= hdr_cnt_next;
            final_reg   <= final_next;
            opcode_reg  <= opcode_next;
            masked_reg  <= masked_next;
            len_reg     <= len_next;
            key_reg     <= key_next;
            left_reg    <= left_next;
            kidx_reg    <= kidx_next;
        end
    end

`ifndef SYNTHESIS
    // The payload phase always has bytes still due.
    a_left_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DATA |-> left_reg != '0)
        else $error("payload phase with no bytes left");

    // The extended header phase always has header bytes still due.
    a_hdr_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_EXT |-> (hdr_cnt_reg != '0 &&
                                 hdr_cnt_reg <= EXT_BYTES_64 + KEY_BYTES))
        else $error("header byte count out of range");

    // An unmasked frame never carries a key into its payload.
    a_key_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA && !masked_reg) |-> key_reg == '0)
        else $error("unmasked payload with a nonzero key");
`endif

endmodule

### rtl/core/wsfp_obuf.sv
module wsfp_obuf (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  wsfp_pkg::res_t push_data,
    output logic           ready,
    output logic           out_valid,
    input  logic           out_ready,
    output wsfp_pkg::res_t out_data
);
    import wsfp_pkg::*;

    logic out_valid_reg;
    logic skid_valid_reg;
    res_t out_reg;
    res_t skid_reg;
    logic pop;

    assign pop       = out_valid_reg && out_ready;
    assign ready     = !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Output register with a skid stage behind it.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (!out_valid_reg || pop)
            begin
                if (skid_valid_reg)
                begin
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= push;
                end
            end
            else if (push)
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || pop)
        begin
            if (skid_valid_reg)
            begin
                out_reg <= skid_reg;
            end
            else if (push)
            begin
                out_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

`ifndef SYNTHESIS
    // The skid stage is only occupied behind a full output register.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    // No result arrives while the skid stage is full.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && skid_valid_reg))
        else $error("result pushed into a full buffer");

    // The skid stage fills only when the output was stalled.
    a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !out_ready))
        else $error("skid stage filled without a stall");
`endif

endmodule

### rtl/core/websocket_frame_parser.sv
// Channel  Dir  Fields
// s        in   tdata[7:0] = stream_byte
// m        out  tdata = final_flag, frame_opcode, mask_flag, payload_length,
//                       payload_byte (lowest bit up); tuser = kind; tlast = last
//
// One byte is taken per cycle while s_tready is high; results are registered.
// The parse logic sits between the byte handshake and the output register.
// Reset is asynchronous and active low; it returns the parser to the first
// header byte and empties the output register and skid stage.
// A stall on m fills the skid stage, after which s_tready drops until it drains.
module websocket_frame_parser (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,  // stream_byte
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // final_flag, frame_opcode[3:0], mask_flag, payload_length[63:0],
    // payload_byte[7:0], zero padding
    output logic [wsfp_pkg::M_TDATA_W-1:0]    m_tdata,
    output logic                              m_tuser,  // kind
    output logic                              m_tlast   // last
);
    import wsfp_pkg::*;

    logic in_fire;
    logic res_valid;
    res_t res;
    res_t out_res;

    assign in_fire = s_tvalid && s_tready;

    // Header and payload parsing.
    wsfp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .res_valid (res_valid),
        .res       (res)
    );

    // Result register and skid stage.
    wsfp_obuf u_obuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (res_valid),
        .push_data (res),
        .ready     (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_res)
    );

    // Pack the result fields onto the master side.
    assign m_tdata = M_TDATA_W'({out_res.payload_byte, out_res.payload_length,
                                 out_res.mask_flag, out_res.frame_opcode,
                                 out_res.final_flag});
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule
